@@ src/gem_pkg.sv @@
// Shared constants, types and the kernel functions for the gradient edge block
`default_nettype none
package gem_pkg;

    localparam int MaxWidth  = 2048;
    localparam int MaxHeight = 2048;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int RowW      = 16;
    localparam int CfgW      = 12;
    localparam int GradW     = 11;
    localparam int MagW      = 11;
    localparam int SqW       = 21;
    localparam int SqrtSteps = (SqW + 1) / 2;
    localparam int QueueDepth = 2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    // One classified item handed from front to back
    typedef struct packed {
        logic [7:0] top_l, top_c, top_r;
        logic [7:0] mid_l, mid_c, mid_r;
        logic [7:0] bot_l, bot_c, bot_r;
        logic       mode;
        logic       last;
    } gem_job_t;

    // Masked window to gradients
    function automatic logic signed [GradW-1:0] grad_x_f(input gem_job_t j);
        logic signed [GradW-1:0] s;
        logic signed [GradW-1:0] m;
        begin
            m = j.mode ? GradW'(1) : GradW'(2);
            s = $signed({3'b0, j.top_r}) - $signed({3'b0, j.top_l})
              + $signed({3'b0, j.bot_r}) - $signed({3'b0, j.bot_l})
              + m * ($signed({3'b0, j.mid_r}) - $signed({3'b0, j.mid_l}));
            grad_x_f = s;
        end
    endfunction

    function automatic logic signed [GradW-1:0] grad_y_f(input gem_job_t j);
        logic signed [GradW-1:0] s;
        logic signed [GradW-1:0] m;
        begin
            m = j.mode ? GradW'(1) : GradW'(2);
            s = $signed({3'b0, j.top_l}) - $signed({3'b0, j.bot_l})
              + $signed({3'b0, j.top_r}) - $signed({3'b0, j.bot_r})
              + m * ($signed({3'b0, j.top_c}) - $signed({3'b0, j.bot_c}));
            grad_y_f = s;
        end
    endfunction

endpackage
`default_nettype wire

@@ src/gem_front.sv @@
// Front end: line stores, window, position tracking and tap masking
`default_nettype none
module gem_front
    import gem_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_valid,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [CfgW-1:0] cfg_data,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [7:0]      s_pixel_in,
    input  wire logic            s_flush,
    output logic                 job_valid,
    output gem_job_t             job,
    input  wire logic            job_ready
);

    // Front holds one accepted item through a read pass and then a compute pass (IDLE, then WORK)
    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_WORK = 1'b1;

    logic [CfgW-1:0] width_reg, height_reg;
    logic            mode_reg;
    logic [0:0]      state_reg, state_next;
    logic [7:0]      older_mem [MaxWidth];
    logic [7:0]      newer_mem [MaxWidth];
    logic [7:0]      top_rd_reg, mid_rd_reg, pix_reg;
    logic [ColW:0]   in_col_reg, out_col_reg;
    logic [RowW-1:0] in_row_reg, out_row_reg;
    logic [7:0]      win_reg [3][3];
    logic            job_valid_reg;
    gem_job_t        job_reg;

    logic [ColW:0]   w_eff, h_eff;
    logic            win_ready, last;
    logic [7:0]      nw [3][3];
    logic            row_ok [3];
    logic            col_ok [3];
    logic [ColW:0]   in_col_inc;
    logic            accept;

    // Clamp dimensions to 1..max
    always_comb begin
        if (width_reg == '0) w_eff = (ColW+1)'(1);
        else if (width_reg > CfgW'(MaxWidth)) w_eff = (ColW+1)'(MaxWidth);
        else w_eff = (ColW+1)'(width_reg);
        if (height_reg == '0) h_eff = (ColW+1)'(1);
        else if (height_reg > CfgW'(MaxHeight)) h_eff = (ColW+1)'(MaxHeight);
        else h_eff = (ColW+1)'(height_reg);
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CfgW'(640);
            height_reg <= CfgW'(480);
            mode_reg   <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_MODE:   mode_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && !(job_valid_reg && !job_ready);
    assign accept  = s_valid && s_ready;

    // Line store reads and writes; read the old column, write the new pixel
    always_ff @(posedge aclk) begin
        if (accept) begin
            top_rd_reg <= older_mem[in_col_reg[ColW-1:0]];
            mid_rd_reg <= newer_mem[in_col_reg[ColW-1:0]];
            pix_reg    <= s_flush ? 8'd0 : s_pixel_in;
        end
        if (state_reg == ST_WORK) begin
            older_mem[in_col_reg[ColW-1:0]] <= mid_rd_reg;
            newer_mem[in_col_reg[ColW-1:0]] <= pix_reg;
        end
    end

    // Shifted window and masking
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            nw[k][0] = win_reg[k][1];
            nw[k][1] = win_reg[k][2];
        end
        nw[0][2] = top_rd_reg;
        nw[1][2] = mid_rd_reg;
        nw[2][2] = pix_reg;
        win_ready = (in_row_reg >= RowW'(2)) ||
                    (in_row_reg == RowW'(1) && in_col_reg >= (ColW+1)'(1));
        // Row above and column left also lie outside once the position is past a cut size
        row_ok[0] = (out_row_reg != '0) && (out_row_reg <= RowW'(h_eff));
        row_ok[1] = out_row_reg < RowW'(h_eff);
        row_ok[2] = (out_row_reg + RowW'(1)) < RowW'(h_eff);
        col_ok[0] = (out_col_reg != '0) && (out_col_reg <= w_eff);
        col_ok[1] = out_col_reg < w_eff;
        col_ok[2] = (out_col_reg + (ColW+1)'(1)) < w_eff;
        last = (out_row_reg >= RowW'(h_eff - (ColW+1)'(1))) &&
               (out_col_reg >= w_eff - (ColW+1)'(1));
        in_col_inc = in_col_reg + (ColW+1)'(1);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_WORK;
            ST_WORK: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Advance window, counters and emit a job
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            job_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
                for (int l = 0; l < 3; l++) win_reg[k][l] <= 8'd0;
        end else begin
            state_reg <= state_next;
            if (job_valid_reg && job_ready && !(state_reg == ST_WORK && win_ready))
                job_valid_reg <= 1'b0;
            if (state_reg == ST_WORK) begin
                win_reg <= nw;
                if (win_ready) begin
                    job_valid_reg <= 1'b1;
                    job_reg.top_l <= (row_ok[0] && col_ok[0]) ? nw[0][0] : 8'd0;
                    job_reg.top_c <= (row_ok[0] && col_ok[1]) ? nw[0][1] : 8'd0;
                    job_reg.top_r <= (row_ok[0] && col_ok[2]) ? nw[0][2] : 8'd0;
                    job_reg.mid_l <= (row_ok[1] && col_ok[0]) ? nw[1][0] : 8'd0;
                    job_reg.mid_c <= (row_ok[1] && col_ok[1]) ? nw[1][1] : 8'd0;
                    job_reg.mid_r <= (row_ok[1] && col_ok[2]) ? nw[1][2] : 8'd0;
                    job_reg.bot_l <= (row_ok[2] && col_ok[0]) ? nw[2][0] : 8'd0;
                    job_reg.bot_c <= (row_ok[2] && col_ok[1]) ? nw[2][1] : 8'd0;
                    job_reg.bot_r <= (row_ok[2] && col_ok[2]) ? nw[2][2] : 8'd0;
                    job_reg.mode  <= mode_reg;
                    job_reg.last  <= last;
                end
                if (win_ready && last) begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end else begin
                    if (in_col_inc >= w_eff) begin
                        in_col_reg <= '0;
                        if (in_row_reg != '1) in_row_reg <= in_row_reg + RowW'(1);
                    end else begin
                        in_col_reg <= in_col_inc;
                    end
                    if (win_ready) begin
                        if (out_col_reg + (ColW+1)'(1) >= w_eff) begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + RowW'(1);
                        end else begin
                            out_col_reg <= out_col_reg + (ColW+1)'(1);
                        end
                    end
                end
            end
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule
`default_nettype wire

@@ src/gem_queue.sv @@
// Two-entry request queue between front and back
`default_nettype none
module gem_queue
    import gem_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     wr_valid,
    output logic          wr_ready,
    input  wire gem_job_t wr_data,
    output logic          rd_valid,
    input  wire logic     rd_ready,
    output gem_job_t      rd_data
);

    gem_job_t    slot_reg [QueueDepth];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;

    assign wr_ready = cnt_reg != 2'(QueueDepth);
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = slot_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Store and count requests
    always_ff @(posedge aclk) begin
        if (push) slot_reg[wp_reg] <= wr_data;
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule
`default_nettype wire

@@ src/gem_back.sv @@
// Back end: gradients, squaring and bit-serial square root
`default_nettype none
module gem_back
    import gem_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        job_valid,
    output logic             job_ready,
    input  wire gem_job_t    job,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [GradW-1:0] m_grad_x,
    output logic [GradW-1:0] m_grad_y,
    output logic [MagW-1:0]  m_magnitude,
    output logic             m_frame_end
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQ   = 2'd1;
    localparam logic [1:0] ST_ROOT = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;
    localparam int StepW = $clog2(SqrtSteps + 1);

    logic [1:0]              state_reg;
    logic signed [GradW-1:0] gx_reg, gy_reg;
    logic                    last_reg;
    logic [SqW-1:0]          rem_reg;
    logic [SqW-1:0]          res_reg;
    logic [SqW-1:0]          bit_reg;
    logic [StepW-1:0]        step_reg;
    logic                    m_valid_reg;
    logic [GradW-1:0]        o_gx_reg, o_gy_reg;
    logic [MagW-1:0]         o_mag_reg;
    logic                    o_end_reg;
    logic [SqW-1:0]          trial;

    assign job_ready = state_reg == ST_IDLE;
    assign trial     = res_reg + bit_reg;

    // Sequence one request: gradients, sum of squares, root, output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_OUT) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (job_valid) begin
                    gx_reg    <= grad_x_f(job);
                    gy_reg    <= grad_y_f(job);
                    last_reg  <= job.last;
                    state_reg <= ST_SQ;
                end
                ST_SQ: begin
                    rem_reg   <= SqW'(32'(gx_reg * gx_reg) + 32'(gy_reg * gy_reg));
                    res_reg   <= '0;
                    bit_reg   <= SqW'(1) << (2 * (SqrtSteps - 1));
                    step_reg  <= StepW'(SqrtSteps);
                    state_reg <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (rem_reg >= trial) begin
                        rem_reg <= rem_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg  <= bit_reg >> 2;
                    step_reg <= step_reg - StepW'(1);
                    if (step_reg == StepW'(1)) state_reg <= ST_OUT;
                end
                ST_OUT: if (!m_valid_reg || m_ready) begin
                    m_valid_reg <= 1'b1;
                    o_gx_reg    <= gx_reg;
                    o_gy_reg    <= gy_reg;
                    o_mag_reg   <= res_reg[MagW-1:0];
                    o_end_reg   <= last_reg;
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_grad_x    = o_gx_reg;
    assign m_grad_y    = o_gy_reg;
    assign m_magnitude = o_mag_reg;
    assign m_frame_end = o_end_reg;

endmodule
`default_nettype wire

@@ src/gradient_edge_magnitude_3x3.sv @@
// Top level of the 3x3 gradient edge magnitude block
// Front takes no new pixel until done with the last, nor while its job waits.
// Back takes one result at a time: gradients, squaring, 11-step root, output.
// Front reads then writes its line store; the serial root sets throughput.
// A result forms when the pixel width+1 items after its centre pixel is taken.
// Synchronous active-low reset clears counters, window and config to defaults.
`default_nettype none
module gradient_edge_magnitude_3x3
    import gem_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [CfgW-1:0] cfg_data,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [7:0]      s_pixel_in,
    input  wire logic            s_flush,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [GradW-1:0]     m_grad_x,
    output logic [GradW-1:0]     m_grad_y,
    output logic [MagW-1:0]      m_magnitude,
    output logic                 m_frame_end
);

    logic     f_valid, f_ready, b_valid, b_ready;
    gem_job_t f_job, b_job;

    assign cfg_ready = 1'b1;

    gem_front u_front (
        .aclk, .aresetn, .cfg_valid, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_pixel_in, .s_flush,
        .job_valid(f_valid), .job(f_job), .job_ready(f_ready)
    );

    gem_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
    );

    gem_back u_back (
        .aclk, .aresetn,
        .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
        .m_valid, .m_ready, .m_grad_x, .m_grad_y, .m_magnitude, .m_frame_end
    );

endmodule
`default_nettype wire

@@ src/gem_checker.sv @@
// Port-level checker for the gradient edge block, bound to the top level
`default_nettype none
module gem_checker
    import gem_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_valid,
    input wire logic             s_ready,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire logic [GradW-1:0] m_grad_x,
    input wire logic [GradW-1:0] m_grad_y,
    input wire logic [MagW-1:0]  m_magnitude
);

    // Output request holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_magnitude))
        else $error("output request dropped or changed");

    // Magnitude never exceeds the largest possible value
    a_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_magnitude <= MagW'(1442))
        else $error("magnitude out of range");

    // Zero gradients give zero magnitude
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_grad_x == '0 && m_grad_y == '0 |-> m_magnitude == '0)
        else $error("nonzero magnitude for flat window");

    // No output right after reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // Front never takes two pixels on consecutive edges
    a_pace: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in a row");

endmodule

bind gradient_edge_magnitude_3x3 gem_checker u_gem_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
    .m_grad_x, .m_grad_y, .m_magnitude
);
`default_nettype wire

@@ tb/tb_gradient_edge_magnitude_3x3.sv @@
// Testbench for the 3x3 gradient edge magnitude block: directed frames and random frames
module tb_gradient_edge_magnitude_3x3;
    import gem_pkg::*;

    localparam int WatchdogLimit = 4000;
    localparam int SettleCycles  = 120;
    localparam int HoldCycles    = 400;

    typedef struct {
        logic [GradW-1:0] grad_x;
        logic [GradW-1:0] grad_y;
        logic [MagW-1:0]  magnitude;
        logic             frame_end;
    } edge_result_t;

    // Predict gradient results from accepted pixels and compare them to the output
    class edge_scoreboard;
        byte unsigned older_row[MaxWidth];
        byte unsigned newer_row[MaxWidth];
        byte unsigned win[3][3];
        int in_col, in_row, out_col, out_row;
        int reg_width, reg_height;
        bit reg_mode;
        edge_result_t expected_q[$];
        int errors;
        int results_seen;

        function new();
            foreach (older_row[i]) begin
                older_row[i] = 0;
                newer_row[i] = 0;
            end
            foreach (win[k, l]) win[k][l] = 0;
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            reg_width = 640;
            reg_height = 480;
            reg_mode = 0;
            errors = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [CfgW-1:0] data);
            case (idx)
                REG_WIDTH:  reg_width = data;
                REG_HEIGHT: reg_height = data;
                REG_MODE:   reg_mode = data[0];
                default: ;
            endcase
        endfunction

        function int eff_dim(int v, int maxv);
            if (v == 0) return 1;
            return (v > maxv) ? maxv : v;
        endfunction

        function int root_floor(int v);
            int lo, hi, mid;
            lo = 0;
            hi = 2048;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (mid * mid <= v) lo = mid;
                else hi = mid - 1;
            end
            return lo;
        endfunction

        function bit frame_idle();
            return in_col == 0 && in_row == 0 && out_col == 0 && out_row == 0;
        endfunction

        // Advance the window by one request and queue the result it causes
        function void note_pixel(logic [7:0] pixel, logic flush);
            int w, h, c, gx, gy, r, q, kx, ky;
            byte unsigned pix, top, mid;
            bit ready, last;
            edge_result_t res;
            w = eff_dim(reg_width, MaxWidth);
            h = eff_dim(reg_height, MaxHeight);
            pix = flush ? 8'd0 : pixel;
            c = in_col % MaxWidth;
            top = older_row[c];
            mid = newer_row[c];
            ready = in_row >= 2 || (in_row == 1 && in_col >= 1);
            older_row[c] = mid;
            newer_row[c] = pix;
            for (int k = 0; k < 3; k++) begin
                win[k][0] = win[k][1];
                win[k][1] = win[k][2];
            end
            win[0][2] = top;
            win[1][2] = mid;
            win[2][2] = pix;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                if (in_row < 16'hFFFF) in_row++;
            end
            if (!ready) return;
            gx = 0;
            gy = 0;
            for (int k = 0; k < 3; k++) begin
                r = out_row - 1 + k;
                if (r < 0 || r >= h) continue;
                for (int l = 0; l < 3; l++) begin
                    q = out_col - 1 + l;
                    if (q < 0 || q >= w) continue;
                    // Center row and column weigh double under Sobel
                    kx = (l - 1) * ((k == 1 && !reg_mode) ? 2 : 1);
                    ky = (1 - k) * ((l == 1 && !reg_mode) ? 2 : 1);
                    gx += win[k][l] * kx;
                    gy += win[k][l] * ky;
                end
            end
            last = out_row >= h - 1 && out_col >= w - 1;
            res.grad_x = gx[GradW-1:0];
            res.grad_y = gy[GradW-1:0];
            res.magnitude = MagW'(root_floor(gx * gx + gy * gy));
            res.frame_end = last;
            expected_q.push_back(res);
            if (last) begin
                in_col = 0;
                in_row = 0;
                out_col = 0;
                out_row = 0;
            end else begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("MISMATCH at result %0d: %s", results_seen, what);
        endtask

        // Compare one result field by field with the oldest expectation
        task check_result(logic [GradW-1:0] gx, logic [GradW-1:0] gy,
                          logic [MagW-1:0] mag, logic fe);
            edge_result_t exp_res;
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected");
                return;
            end
            exp_res = expected_q.pop_front();
            if (gx !== exp_res.grad_x)
                report_mismatch($sformatf("grad_x %0d, want %0d", $signed(gx),
                                          $signed(exp_res.grad_x)));
            if (gy !== exp_res.grad_y)
                report_mismatch($sformatf("grad_y %0d, want %0d", $signed(gy),
                                          $signed(exp_res.grad_y)));
            if (mag !== exp_res.magnitude)
                report_mismatch($sformatf("magnitude %0d, want %0d", mag,
                                          exp_res.magnitude));
            if (fe !== exp_res.frame_end)
                report_mismatch($sformatf("frame_end %0b, want %0b", fe,
                                          exp_res.frame_end));
        endtask
    endclass

    logic            aclk;
    logic            aresetn;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [1:0]      cfg_index;
    logic [CfgW-1:0] cfg_data;
    logic            s_valid;
    logic            s_ready;
    logic [7:0]      s_pixel_in;
    logic            s_flush;
    logic            m_valid;
    logic            m_ready;
    logic [GradW-1:0] m_grad_x;
    logic [GradW-1:0] m_grad_y;
    logic [MagW-1:0] m_magnitude;
    logic            m_frame_end;

    edge_scoreboard sb;
    int  pixels_sent;
    int  frames_run;
    int  idle_cycles;
    bit  no_gaps;
    bit  held_off;

    gradient_edge_magnitude_3x3 dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pixel_in(s_pixel_in), .s_flush(s_flush),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_grad_x(m_grad_x), .m_grad_y(m_grad_y),
        .m_magnitude(m_magnitude), .m_frame_end(m_frame_end)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Drop the input request, then wait until every expected result is out
    task settle();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task write_reg(logic [1:0] idx, logic [CfgW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Offer one pixel request, at times with a random gap ahead of it
    task send_pixel(logic [7:0] pixel, logic flush);
        if (!no_gaps && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 29);
        end
        s_valid    <= 1'b1;
        s_pixel_in <= pixel;
        s_flush    <= flush;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(pixel, flush);
        pixels_sent++;
    endtask

    // Pixel for a pattern: 0 random, 1/2 bright right/left column, 3/4 bright top/bottom row
    function logic [7:0] pattern_pixel(int kind, int row, int col, int w, int h);
        case (kind)
            1: return (col == w - 1) ? 8'hFF : 8'h00;
            2: return (col == 0) ? 8'hFF : 8'h00;
            3: return (row == 0) ? 8'hFF : 8'h00;
            4: return (row == h - 1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Drain the frame with flush or stray pixel requests until it closes
    task finish_frame(int stray_pct);
        while (!sb.frame_idle())
            send_pixel(8'($urandom_range(255)), $urandom_range(99) >= stray_pct);
        frames_run++;
    endtask

    task run_frame(int w_reg, int h_reg, bit mode, int kind, int flush_pct, int stray_pct);
        int w, h;
        settle();
        write_reg(REG_WIDTH, CfgW'(w_reg));
        write_reg(REG_HEIGHT, CfgW'(h_reg));
        write_reg(REG_MODE, CfgW'(mode));
        w = sb.eff_dim(w_reg, MaxWidth);
        h = sb.eff_dim(h_reg, MaxHeight);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                send_pixel(pattern_pixel(kind, r, c, w, h), $urandom_range(99) < flush_pct);
        finish_frame(stray_pct);
    endtask

    // Stimulus
    initial begin
        sb = new();
        pixels_sent = 0;
        frames_run = 0;
        no_gaps = 0;
        aresetn    <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_WIDTH;
        cfg_data   <= '0;
        s_valid    <= 1'b0;
        s_pixel_in <= '0;
        s_flush    <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: full-scale gradients of both signs under both kernels
        run_frame(3, 3, 0, 1, 0, 0);
        run_frame(3, 3, 0, 4, 0, 0);
        run_frame(3, 3, 1, 3, 0, 0);
        run_frame(3, 3, 1, 2, 0, 0);
        // Zero sizes count as one
        run_frame(0, 0, 0, 0, 0, 0);
        // Flush inside a frame and stray pixels after the last row
        run_frame(4, 2, 1, 0, 40, 100);

        // Size cut mid-frame below the current output row and column
        settle();
        write_reg(REG_WIDTH, CfgW'(4));
        write_reg(REG_HEIGHT, CfgW'(6));
        write_reg(REG_MODE, CfgW'(0));
        for (int i = 0; i < 16; i++) send_pixel(8'($urandom_range(255)), 1'b0);
        settle();
        write_reg(REG_WIDTH, CfgW'(2));
        write_reg(REG_HEIGHT, CfgW'(1));
        finish_frame(50);

        // Random frames, mostly small, with one stretch without gaps
        while (pixels_sent < 1350) begin
            int w_reg, h_reg;
            no_gaps = pixels_sent >= 500 && pixels_sent < 800;
            w_reg = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(1, 8);
            h_reg = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(1, 6);
            run_frame(w_reg, h_reg, $urandom_range(1), 0, 8, $urandom_range(1) ? 0 : 30);
        end
        no_gaps = 0;

        // Out-of-range sizes saturate; a long first row, then cut back to close the frame
        settle();
        write_reg(REG_WIDTH, CfgW'(4095));
        write_reg(REG_HEIGHT, CfgW'(4095));
        write_reg(REG_MODE, CfgW'(1));
        for (int i = 0; i < 40; i++) send_pixel(8'($urandom_range(255)), 1'b0);
        settle();
        write_reg(REG_WIDTH, CfgW'(3));
        write_reg(REG_HEIGHT, CfgW'(1));
        finish_frame(10);

        settle();
        s_valid <= 1'b0;
        if (sb.expected_q.size() != 0)
            sb.report_mismatch($sformatf("%0d results never came", sb.expected_q.size()));
        $display("Covered %0d frames, %0d pixel requests, %0d results checked",
                 frames_run, pixels_sent, sb.results_seen);
        $display("Both kernels, size extremes, mid-frame resize, flush and stray pixels");
        if (sb.errors == 0) begin
            $display("tb_gradient_edge_magnitude_3x3 passed");
        end else begin
            $display("tb_gradient_edge_magnitude_3x3 failed");
        end
        $finish;
    end

    // Result side: check, stall at random, and hold off once for a long stretch
    initial begin
        held_off = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check_result(m_grad_x, m_grad_y, m_magnitude, m_frame_end);
            if (!held_off && sb.results_seen >= 150) begin
                held_off = 1;
                m_ready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
            end
            m_ready <= no_gaps || $urandom_range(99) >= 29;
        end
    end

    // Watchdog: end the run if nothing moves for too long
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
                $display("Timeout after %0d cycles without a handshake", idle_cycles);
                $display("tb_gradient_edge_magnitude_3x3 failed");
                $finish;
            end
        end
    end

endmodule
